// ===== rtl/core/pds_pkg.sv =====
// Package for the PLL divider search block: widths, default ranges, register
// indexes and the controller/datapath command and status structs.
// No dependencies.
package pds_pkg;

    localparam int unsigned FREQ_W   = 26;
    localparam int unsigned VCO_W    = 29;
    localparam int unsigned CFG_W    = 29;
    localparam int unsigned IDX_W    = 3;
    localparam int unsigned M_W      = 6;
    localparam int unsigned N_W      = 9;
    localparam int unsigned R_W      = 4;
    localparam int unsigned DIV_W    = 6;

    localparam int unsigned DEF_M_MIN = 1;
    localparam int unsigned DEF_M_MAX = 8;
    localparam int unsigned DEF_N_MIN = 8;
    localparam int unsigned DEF_N_MAX = 86;
    localparam int unsigned DEF_R_MIN = 2;
    localparam int unsigned DEF_R_MAX = 8;

    localparam logic [FREQ_W-1:0] RST_CRYSTAL  = 26'd0;
    localparam logic [FREQ_W-1:0] RST_INTERNAL = 26'd16000000;
    localparam logic [FREQ_W-1:0] RST_PIN_MIN  = 26'd4000000;
    localparam logic [FREQ_W-1:0] RST_PIN_MAX  = 26'd16000000;
    localparam logic [VCO_W-1:0]  RST_VCO_MIN  = 29'd64000000;
    localparam logic [VCO_W-1:0]  RST_VCO_MAX  = 29'd344000000;

    typedef enum logic [IDX_W-1:0] {
        REG_CRYSTAL  = 3'd0,
        REG_INTERNAL = 3'd1,
        REG_PIN_MIN  = 3'd2,
        REG_PIN_MAX  = 3'd3,
        REG_VCO_MIN  = 3'd4,
        REG_VCO_MAX  = 3'd5,
        REG_DIV_MODE = 3'd6
    } t_reg_idx;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_item;   // latch target and base
        logic div_start;   // start a serial division
        logic div_pin;     // 1: base/M, 0: vco/div
        logic calc_vco;    // vco = pin * n
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_done;
        logic pin_ok;
        logic vco_ok;
        logic hit;
    } t_dp_sts;

endpackage

// ===== rtl/core/pds_ctrl.sv =====
// Controller of the PLL divider search: walks M, N, R and sequences the datapath.
// Depends on pds_pkg.
module pds_ctrl #(
    parameter int unsigned M_MIN = pds_pkg::DEF_M_MIN,
    parameter int unsigned M_MAX = pds_pkg::DEF_M_MAX,
    parameter int unsigned N_MIN = pds_pkg::DEF_N_MIN,
    parameter int unsigned N_MAX = pds_pkg::DEF_N_MAX,
    parameter int unsigned R_MIN = pds_pkg::DEF_R_MIN,
    parameter int unsigned R_MAX = pds_pkg::DEF_R_MAX
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    output logic                      o_busy,
    input  pds_pkg::t_dp_sts          i_sts,
    output pds_pkg::t_dp_cmd          o_cmd,
    output logic [pds_pkg::M_W-1:0]   o_m,
    output logic [pds_pkg::N_W-1:0]   o_n,
    output logic [pds_pkg::R_W-1:0]   o_r,
    output logic                      o_done,
    output logic                      o_found
);

    typedef enum logic [2:0] {
        S_IDLE, S_MSTEP, S_PDIV, S_NSTEP, S_VCO, S_RSTEP, S_RDIV
    } t_state;

    // Counters carry one spare bit so that a loop ending at the field's top value
    // still terminates.
    localparam logic [pds_pkg::M_W:0] MLO = (pds_pkg::M_W+1)'(M_MIN);
    localparam logic [pds_pkg::M_W:0] MHI = (pds_pkg::M_W+1)'(M_MAX);
    localparam logic [pds_pkg::N_W:0] NLO = (pds_pkg::N_W+1)'(N_MIN);
    localparam logic [pds_pkg::N_W:0] NHI = (pds_pkg::N_W+1)'(N_MAX);
    localparam logic [pds_pkg::R_W:0] RLO = (pds_pkg::R_W+1)'(R_MIN);
    localparam logic [pds_pkg::R_W:0] RHI = (pds_pkg::R_W+1)'(R_MAX);

    t_state r_state;
    logic [pds_pkg::M_W:0] r_m;
    logic [pds_pkg::N_W:0] r_n;
    logic [pds_pkg::R_W:0] r_r;
    logic r_done, r_found;

    assign o_busy  = (r_state != S_IDLE);
    assign o_m     = r_m[pds_pkg::M_W-1:0];
    assign o_n     = r_n[pds_pkg::N_W-1:0];
    assign o_r     = r_r[pds_pkg::R_W-1:0];
    assign o_done  = r_done;
    assign o_found = r_found;

    // Commands decode from the present state.
    always_comb begin
        o_cmd           = '0;
        o_cmd.load_item = (r_state == S_IDLE) && i_start;
        o_cmd.div_start = (r_state == S_MSTEP && r_m <= MHI && r_m != '0)
                        || (r_state == S_RSTEP && r_r <= RHI);
        o_cmd.div_pin   = (r_state == S_MSTEP);
        o_cmd.calc_vco  = (r_state == S_NSTEP && r_n <= NHI);
    end

    // Search sequencer: counters hold the candidate under test.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_m     <= '0;
            r_n     <= '0;
            r_r     <= '0;
            r_done  <= 1'b0;
            r_found <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_m     <= MLO;
                        r_state <= S_MSTEP;
                    end
                end
                S_MSTEP: begin
                    if (M_MIN > M_MAX || r_m > MHI) begin
                        r_done  <= 1'b1;
                        r_found <= 1'b0;
                        r_m     <= '0;
                        r_n     <= '0;
                        r_r     <= '0;
                        r_state <= S_IDLE;
                    end else if (r_m == '0) begin
                        r_m <= r_m + 1'b1;
                    end else begin
                        r_state <= S_PDIV;
                    end
                end
                S_PDIV: begin
                    if (i_sts.div_done) begin
                        if (i_sts.pin_ok) begin
                            r_n     <= NLO;
                            r_state <= S_NSTEP;
                        end else begin
                            r_m     <= r_m + 1'b1;
                            r_state <= S_MSTEP;
                        end
                    end
                end
                S_NSTEP: begin
                    if (N_MIN > N_MAX || r_n > NHI) begin
                        r_m     <= r_m + 1'b1;
                        r_state <= S_MSTEP;
                    end else begin
                        r_state <= S_VCO;
                    end
                end
                S_VCO: begin
                    if (i_sts.vco_ok) begin
                        r_r     <= RLO;
                        r_state <= S_RSTEP;
                    end else begin
                        r_n     <= r_n + 1'b1;
                        r_state <= S_NSTEP;
                    end
                end
                S_RSTEP: begin
                    if (R_MIN > R_MAX || r_r > RHI) begin
                        r_n     <= r_n + 1'b1;
                        r_state <= S_NSTEP;
                    end else begin
                        r_state <= S_RDIV;
                    end
                end
                S_RDIV: begin
                    if (i_sts.div_done) begin
                        if (i_sts.hit) begin
                            r_done  <= 1'b1;
                            r_found <= 1'b1;
                            r_state <= S_IDLE;
                        end else begin
                            r_r     <= r_r + 1'b1;
                            r_state <= S_RSTEP;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // A result strobe only leaves the search states.
    a_done_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_state == S_MSTEP || r_state == S_RDIV))
        else $error("done without a finished search");
    // A found result carries an in-range M.
    a_found_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && r_found) |-> (r_m >= MLO && r_m <= MHI && r_m != '0))
        else $error("found with M out of range");
    // The controller is idle whenever the result strobe is high.
    a_idle_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> r_state == S_IDLE)
        else $error("controller not idle after result");

endmodule

// ===== rtl/core/pds_dp.sv =====
// Datapath of the PLL divider search: registers, VCO multiply, and a bit-serial
// divider shared by base/M and vco/div. Depends on pds_pkg.
module pds_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  pds_pkg::t_dp_cmd            i_cmd,
    output pds_pkg::t_dp_sts            o_sts,
    input  logic [pds_pkg::VCO_W-1:0]   i_target,
    input  logic                        i_use_crystal,
    input  logic [pds_pkg::FREQ_W-1:0]  i_crystal,
    input  logic [pds_pkg::FREQ_W-1:0]  i_internal,
    input  logic [pds_pkg::FREQ_W-1:0]  i_pin_min,
    input  logic [pds_pkg::FREQ_W-1:0]  i_pin_max,
    input  logic [pds_pkg::VCO_W-1:0]   i_vco_min,
    input  logic [pds_pkg::VCO_W-1:0]   i_vco_max,
    input  logic                        i_div_mode,
    input  logic [pds_pkg::M_W-1:0]     i_m,
    input  logic [pds_pkg::N_W-1:0]     i_n,
    input  logic [pds_pkg::R_W-1:0]     i_r
);

    localparam int unsigned PV_W  = pds_pkg::FREQ_W + pds_pkg::N_W;
    localparam int unsigned DVD_W = PV_W;
    localparam int unsigned CNT_W = $clog2(DVD_W + 1);

    logic [pds_pkg::VCO_W-1:0]  r_target;
    logic [pds_pkg::FREQ_W-1:0] r_base;
    logic [pds_pkg::FREQ_W-1:0] r_pin;
    logic [PV_W-1:0]            r_vco;
    logic                       w_vco_ok;
    logic [DVD_W-1:0]           r_quo;
    logic [pds_pkg::DIV_W-1:0]  r_rem;
    logic [pds_pkg::DIV_W-1:0]  r_dsr;
    logic [CNT_W-1:0]           r_cnt;
    logic                       r_busy;
    logic                       r_pmode;
    logic                       r_done;

    logic [pds_pkg::DIV_W+1:0]  w_trial;
    logic [pds_pkg::R_W:0]      w_rsum;
    logic [pds_pkg::DIV_W-1:0]  w_rdiv;
    logic [pds_pkg::DIV_W:0]    w_rem_sh;

    // Output divisor: r+1, doubled in the second divide mode.
    assign w_rsum = {1'b0, i_r} + 1'b1;
    assign w_rdiv = i_div_mode ? {w_rsum, 1'b0} : {1'b0, w_rsum};
    assign w_rem_sh = {r_rem, r_quo[DVD_W-1]};
    assign w_trial  = {1'b0, w_rem_sh} - {2'b00, r_dsr};

    // Restoring division, one quotient bit per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.div_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DVD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Division operands and shifting registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_pmode <= i_cmd.div_pin;
            r_rem   <= '0;
            if (i_cmd.div_pin) begin
                r_quo <= DVD_W'(r_base);
                r_dsr <= pds_pkg::DIV_W'(i_m);
            end else begin
                r_quo <= r_vco;
                r_dsr <= w_rdiv;
            end
        end else if (r_busy) begin
            if (!w_trial[pds_pkg::DIV_W+1]) begin
                r_rem <= w_trial[pds_pkg::DIV_W-1:0];
                r_quo <= {r_quo[DVD_W-2:0], 1'b1};
            end else begin
                r_rem <= w_rem_sh[pds_pkg::DIV_W-1:0];
                r_quo <= {r_quo[DVD_W-2:0], 1'b0};
            end
        end
    end

    // Item latch, PLL input capture and VCO product.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_target <= i_target;
            r_base   <= i_use_crystal ? i_crystal : i_internal;
        end
        if (r_done && r_pmode) begin
            r_pin <= r_quo[pds_pkg::FREQ_W-1:0];
        end
        if (i_cmd.calc_vco) begin
            r_vco    <= PV_W'(r_pin) * PV_W'(i_n);
        end
    end

    assign w_vco_ok = (r_vco >= PV_W'(i_vco_min)) && (r_vco <= PV_W'(i_vco_max));

    always_comb begin
        o_sts          = '0;
        o_sts.div_done = r_done;
        o_sts.pin_ok   = (r_quo >= DVD_W'(i_pin_min)) && (r_quo <= DVD_W'(i_pin_max));
        o_sts.vco_ok   = w_vco_ok;
        o_sts.hit      = (r_quo == DVD_W'(r_target));
    end

endmodule

// ===== rtl/core/pll_divider_search.sv =====
// Top level of the PLL divider search: configuration registers, controller
// and datapath. Depends on pds_pkg, pds_ctrl and pds_dp.
//
//  channel | ports                                         | handshake
//  config  | i_cfg_we, i_cfg_idx, i_cfg_data               | write when i_cfg_we
//  item in | i_target_frequency, i_use_crystal             | start && !busy
//  result  | o_found, o_divider_m, o_multiplier_n, o_divider_r | o_done, one cycle
//
// Each M costs a step plus a base/M division; with the PLL input in its window
// each N costs a step and a VCO check, each R with the VCO in its window a step
// and a vco/div division, and each finished N or R loop a further step. The
// divider is 35-bit and bit-serial. Reset is synchronous and restores the
// register defaults.
// The result strobe cannot be stalled; busy falls with it.
module pll_divider_search #(
    parameter int unsigned M_MIN = pds_pkg::DEF_M_MIN,
    parameter int unsigned M_MAX = pds_pkg::DEF_M_MAX,
    parameter int unsigned N_MIN = pds_pkg::DEF_N_MIN,
    parameter int unsigned N_MAX = pds_pkg::DEF_N_MAX,
    parameter int unsigned R_MIN = pds_pkg::DEF_R_MIN,
    parameter int unsigned R_MAX = pds_pkg::DEF_R_MAX
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [pds_pkg::IDX_W-1:0]   i_cfg_idx,
    input  logic [pds_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic                        start,
    output logic                        busy,
    input  logic [pds_pkg::VCO_W-1:0]   i_target_frequency,
    input  logic                        i_use_crystal,
    output logic                        o_done,
    output logic                        o_found,
    output logic [pds_pkg::M_W-1:0]     o_divider_m,
    output logic [pds_pkg::N_W-1:0]     o_multiplier_n,
    output logic [pds_pkg::R_W-1:0]     o_divider_r
);

    logic [pds_pkg::FREQ_W-1:0] r_crystal, r_internal, r_pin_min, r_pin_max;
    logic [pds_pkg::VCO_W-1:0]  r_vco_min, r_vco_max;
    logic                       r_div_mode;

    pds_pkg::t_dp_cmd w_cmd;
    pds_pkg::t_dp_sts w_sts;
    logic [pds_pkg::M_W-1:0] w_m;
    logic [pds_pkg::N_W-1:0] w_n;
    logic [pds_pkg::R_W-1:0] w_r;

    // Configuration register file.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crystal  <= pds_pkg::RST_CRYSTAL;
            r_internal <= pds_pkg::RST_INTERNAL;
            r_pin_min  <= pds_pkg::RST_PIN_MIN;
            r_pin_max  <= pds_pkg::RST_PIN_MAX;
            r_vco_min  <= pds_pkg::RST_VCO_MIN;
            r_vco_max  <= pds_pkg::RST_VCO_MAX;
            r_div_mode <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pds_pkg::REG_CRYSTAL:  r_crystal  <= i_cfg_data[pds_pkg::FREQ_W-1:0];
                pds_pkg::REG_INTERNAL: r_internal <= i_cfg_data[pds_pkg::FREQ_W-1:0];
                pds_pkg::REG_PIN_MIN:  r_pin_min  <= i_cfg_data[pds_pkg::FREQ_W-1:0];
                pds_pkg::REG_PIN_MAX:  r_pin_max  <= i_cfg_data[pds_pkg::FREQ_W-1:0];
                pds_pkg::REG_VCO_MIN:  r_vco_min  <= i_cfg_data;
                pds_pkg::REG_VCO_MAX:  r_vco_max  <= i_cfg_data;
                pds_pkg::REG_DIV_MODE: r_div_mode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    pds_ctrl #(
        .M_MIN(M_MIN), .M_MAX(M_MAX), .N_MIN(N_MIN),
        .N_MAX(N_MAX), .R_MIN(R_MIN), .R_MAX(R_MAX)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .o_m     (w_m),
        .o_n     (w_n),
        .o_r     (w_r),
        .o_done  (o_done),
        .o_found (o_found)
    );

    pds_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_target      (i_target_frequency),
        .i_use_crystal (i_use_crystal),
        .i_crystal     (r_crystal),
        .i_internal    (r_internal),
        .i_pin_min     (r_pin_min),
        .i_pin_max     (r_pin_max),
        .i_vco_min     (r_vco_min),
        .i_vco_max     (r_vco_max),
        .i_div_mode    (r_div_mode),
        .i_m           (w_m),
        .i_n           (w_n),
        .i_r           (w_r)
    );

    assign o_divider_m    = w_m;
    assign o_multiplier_n = w_n;
    assign o_divider_r    = w_r;

endmodule
